// ===== hw/rtl/ten_band_iir_graphic_equalizer_defines.svh =====
// ---------------------------------------------------------------------------
// Graphic equalizer assertion macros
// Shared property forms used by the equalizer RTL.
// ---------------------------------------------------------------------------
`ifndef TEN_BAND_IIR_GRAPHIC_EQUALIZER_DEFINES_SVH
`define TEN_BAND_IIR_GRAPHIC_EQUALIZER_DEFINES_SVH

// same-cycle implication
`define GEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GEQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/geq_pkg.sv =====
// ---------------------------------------------------------------------------
// Graphic equalizer package
// Types, constants and elaboration-time coefficient functions.
// ---------------------------------------------------------------------------
`default_nettype none

package geq_pkg;

    localparam int MAX_BANDS = 10;
    localparam int NUM_TAPS  = 5;
    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 16;
    localparam int MIX_W     = 29;
    localparam int HIST_W    = 32;
    localparam int OPND_W    = 33;
    localparam int PROD_W    = 66;
    localparam int ACC_W     = 100;
    localparam int MIXACC_W  = 46;
    localparam logic [2:0] TAP_LAST = 3'd4;

    localparam logic [63:0] TWO_PI_Q44 = 64'h6487ED5110B4;
    localparam logic [63:0] SQRT2_Q36  = 64'h16A09E667F;
    localparam int QT = 36;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_ACC  = 8'b0000_0100,
        ST_FIN  = 8'b0000_1000,
        ST_GMUL = 8'b0001_0000,
        ST_GACC = 8'b0010_0000,
        ST_DONE = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } geq_state_t;

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_en;
        logic acc_hi;
    } geq_mac_ctrl_t;

    function automatic logic [127:0] udiv(input logic [127:0] n, input logic [127:0] d);
        logic [127:0] q;
        logic [127:0] r;
        int i;
        q = '0;
        r = '0;
        for (i = 127; i >= 0; i--) begin
            r = {r[126:0], n[i]};
            if (r >= d) begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] umul_shift(input logic [63:0] a, input logic [63:0] b,
                                               input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (s - 1));
        return 64'(p >> s);
    endfunction

    function automatic logic signed [63:0] calc_coef(input int k, input int j, input int sr,
                                                     input int low, input int cbits);
        logic [63:0] den;
        logic [63:0] fc;
        logic [63:0] t;
        logic signed [63:0] t2, t3, t4, r1, r3, one, a, v, lim, res;
        logic [127:0] mag, q, r;
        logic neg;
        den = 64'(sr) * 64'd256;
        fc  = 64'(low) << k;
        t   = 64'(udiv({64'd0, TWO_PI_Q44 * fc + (den >> 1)}, {64'd0, den}));
        t2  = umul_shift(t, t, QT);
        t4  = umul_shift(t2, t2, QT);
        t3  = umul_shift(t2, t, QT);
        r3  = umul_shift(SQRT2_Q36, t3, QT);
        r1  = umul_shift(SQRT2_Q36, t, QT);
        one = 64'sd1 <<< QT;
        a   = t4 + r3 + 9 * t2 + 4 * r1 + 16 * one;
        case (j)
            0:       v = t2;
            1:       v = 4 * t4 + 2 * r3 - 8 * r1 - 64 * one;
            2:       v = 6 * t4 - 18 * t2 + 96 * one;
            3:       v = 4 * t4 - 2 * r3 + 8 * r1 - 64 * one;
            default: v = t4 - r3 + 9 * t2 - 4 * r1 + 16 * one;
        endcase
        neg = v < 0;
        mag = {64'd0, (neg ? -v : v)} << 44;
        q   = udiv(mag, {64'd0, a});
        r   = mag - q * {64'd0, a};
        if ((r << 1) >= {64'd0, a}) begin
            q = q + 128'd1;
        end
        res = neg ? -$signed(q[63:0]) : $signed(q[63:0]);
        lim = $signed((64'd1 << (cbits - 1)) - 64'd1);
        if (res > lim) begin
            res = lim;
        end else if (res < -lim - 64'sd1) begin
            res = -lim - 64'sd1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/geq_mac.sv =====
// ---------------------------------------------------------------------------
// Equalizer shared multiply-accumulate unit
// One 33x33 signed multiplier, registered product, wide accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module geq_mac (
    input  wire                                        aclk,
    input  geq_pkg::geq_mac_ctrl_t                     ctrl,
    input  wire logic signed [geq_pkg::OPND_W-1:0]     opnd_a,
    input  wire logic signed [geq_pkg::OPND_W-1:0]     opnd_b,
    output logic signed [geq_pkg::PROD_W-1:0]          prod,
    output logic signed [geq_pkg::ACC_W-1:0]           acc
);
    import geq_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     hi_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  addend;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= opnd_a * opnd_b;
            hi_reg   <= ctrl.acc_hi;
        end
    end

    always_comb begin
        if (hi_reg) begin
            addend = ACC_W'($signed({prod_reg, 32'd0}));
        end else begin
            addend = ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_reg + addend;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ten_band_iir_graphic_equalizer.sv =====
// ---------------------------------------------------------------------------
// Ten-band graphic equalizer
// Octave-spaced fourth-order bandpass filters with gain-weighted mix.
// ---------------------------------------------------------------------------
// Input channel s_*: one Q1.23 sample plus ten Q2.14 band gains per transfer.
// Result channel m_*: Q6.23 gain-weighted mix and ten Q1.23 band outputs.
// Each item runs through one shared 33x33 multiplier: per band, five taps of
// two 32-bit coefficient halves, each a multiply and an accumulate step,
// then round/saturate and the gain product. m_valid rises after the last
// band's gain product has been added to the mix. s_ready is high only
// when no item is in work and no result is pending, so a new item is taken
// only once the result is accepted. A stalled m_ready holds the result and
// keeps s_ready low. Coefficients are constants fixed at elaboration from
// SAMPLE_RATE, LOWEST_CENTER_HZ and COEF_BITS. Reset clears the input history
// and marks all band history entries empty (read as zero); no clearing pass.
// Bands at and above BAND_COUNT output zero and add nothing to the mix.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ten_band_iir_graphic_equalizer_defines.svh"

module ten_band_iir_graphic_equalizer #(
    parameter int SAMPLE_RATE      = 48000,
    parameter int BAND_COUNT       = 10,
    parameter int LOWEST_CENTER_HZ = 32,
    parameter int COEF_BITS        = 48
) (
    input  wire                                          aclk,
    input  wire                                          aresetn,
    input  wire                                          s_valid,
    output logic                                         s_ready,
    input  wire logic signed [geq_pkg::SAMPLE_W-1:0]     s_sample_in,
    input  wire logic [geq_pkg::GAIN_W-1:0]              s_gain_band0,
    input  wire logic [geq_pkg::GAIN_W-1:0]              s_gain_band1,
    input  wire logic [geq_pkg::GAIN_W-1:0]              s_gain_band2,
    input  wire logic [geq_pkg::GAIN_W-1:0]              s_gain_band3,
    input  wire logic [geq_pkg::GAIN_W-1:0]              s_gain_band4,
    input  wire logic [geq_pkg::GAIN_W-1:0]              s_gain_band5,
    input  wire logic [geq_pkg::GAIN_W-1:0]              s_gain_band6,
    input  wire logic [geq_pkg::GAIN_W-1:0]              s_gain_band7,
    input  wire logic [geq_pkg::GAIN_W-1:0]              s_gain_band8,
    input  wire logic [geq_pkg::GAIN_W-1:0]              s_gain_band9,
    output logic                                         m_valid,
    input  wire                                          m_ready,
    output logic signed [geq_pkg::MIX_W-1:0]             m_mix_out,
    output logic signed [geq_pkg::SAMPLE_W-1:0]          m_band0_out,
    output logic signed [geq_pkg::SAMPLE_W-1:0]          m_band1_out,
    output logic signed [geq_pkg::SAMPLE_W-1:0]          m_band2_out,
    output logic signed [geq_pkg::SAMPLE_W-1:0]          m_band3_out,
    output logic signed [geq_pkg::SAMPLE_W-1:0]          m_band4_out,
    output logic signed [geq_pkg::SAMPLE_W-1:0]          m_band5_out,
    output logic signed [geq_pkg::SAMPLE_W-1:0]          m_band6_out,
    output logic signed [geq_pkg::SAMPLE_W-1:0]          m_band7_out,
    output logic signed [geq_pkg::SAMPLE_W-1:0]          m_band8_out,
    output logic signed [geq_pkg::SAMPLE_W-1:0]          m_band9_out
);
    import geq_pkg::*;

    localparam int BAND_W  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int HDEPTH  = BAND_COUNT * 4;
    localparam int HADDR_W = $clog2(HDEPTH);

    geq_state_t state_reg, state_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic [2:0]        tap_reg, tap_next;
    logic              chunk_reg, chunk_next;
    logic [1:0]        head_reg, head_next;
    logic signed [SAMPLE_W-1:0] ih_reg [4];
    logic signed [SAMPLE_W-1:0] smp_reg;
    logic [GAIN_W-1:0]          gain_reg [MAX_BANDS];
    logic signed [OPND_W-1:0]   v_reg, v_next;
    logic signed [MIXACC_W-1:0] mix_reg, mix_next;
    logic signed [SAMPLE_W-1:0] bout_reg [BAND_COUNT];
    logic signed [MIX_W-1:0]    mix_out_reg;
    logic                       m_valid_reg, m_valid_next;

    logic signed [HIST_W-1:0] hist_mem [HDEPTH];
    logic [HDEPTH-1:0]        hist_vld_reg;
    logic signed [HIST_W-1:0] hrd_reg;
    logic                     hrd_vld_reg;
    logic [HADDR_W-1:0]       raddr, waddr;
    logic [1:0]               rslot;

    logic signed [63:0]       coef_tab [BAND_COUNT][NUM_TAPS];
    logic signed [63:0]       coef_cur;
    logic [GAIN_W-1:0]        gain_arr [MAX_BANDS];
    logic signed [SAMPLE_W-1:0] band_port [MAX_BANDS];

    geq_mac_ctrl_t            mac_ctrl;
    logic signed [OPND_W-1:0] opnd_a, opnd_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;

    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [55:0]        y_wide;
    logic signed [HIST_W-1:0]  y_sat;
    logic signed [OPND_W-1:0]  bo_wide;
    logic signed [SAMPLE_W-1:0] bo_sat;
    logic signed [MIXACC_W-1:0] mix_rnd;
    logic signed [MIX_W-1:0]   mix_sat;
    logic signed [OPND_W-1:0]  hist_opnd;

    genvar gk, gj;
    generate
        for (gk = 0; gk < BAND_COUNT; gk++) begin : g_band
            for (gj = 0; gj < NUM_TAPS; gj++) begin : g_tap
                localparam logic signed [63:0] CV =
                    calc_coef(gk, gj, SAMPLE_RATE, LOWEST_CENTER_HZ, COEF_BITS);
                assign coef_tab[gk][gj] = CV;
            end
        end
        for (gk = 0; gk < MAX_BANDS; gk++) begin : g_port
            if (gk < BAND_COUNT) begin : g_used
                assign band_port[gk] = bout_reg[gk];
            end else begin : g_unused
                assign band_port[gk] = '0;
            end
        end
    endgenerate

    assign gain_arr[0] = s_gain_band0;
    assign gain_arr[1] = s_gain_band1;
    assign gain_arr[2] = s_gain_band2;
    assign gain_arr[3] = s_gain_band3;
    assign gain_arr[4] = s_gain_band4;
    assign gain_arr[5] = s_gain_band5;
    assign gain_arr[6] = s_gain_band6;
    assign gain_arr[7] = s_gain_band7;
    assign gain_arr[8] = s_gain_band8;
    assign gain_arr[9] = s_gain_band9;

    assign coef_cur  = coef_tab[band_reg][tap_reg];
    assign hist_opnd = hrd_vld_reg ? -$signed({hrd_reg[HIST_W-1], hrd_reg}) : '0;

    // filter output: round Q44+Q28 sum to Q4.28, then to Q1.23
    always_comb begin
        acc_rnd = acc + (100'sd1 <<< 43);
        y_wide  = 56'(acc_rnd >>> 44);
        if (y_wide > 56'sd2147483647) begin
            y_sat = 32'sh7FFFFFFF;
        end else if (y_wide < -56'sd2147483648) begin
            y_sat = 32'sh80000000;
        end else begin
            y_sat = y_wide[HIST_W-1:0];
        end
        bo_wide = ($signed({y_sat[HIST_W-1], y_sat}) + 33'sd16) >>> 5;
        if (bo_wide > 33'sd8388607) begin
            bo_sat = 24'sh7FFFFF;
        end else if (bo_wide < -33'sd8388608) begin
            bo_sat = 24'sh800000;
        end else begin
            bo_sat = bo_wide[SAMPLE_W-1:0];
        end
        mix_rnd = (mix_reg + 46'sd8192) >>> 14;
        if (mix_rnd > 46'sd268435455) begin
            mix_sat = 29'sh0FFFFFFF;
        end else if (mix_rnd < -46'sd268435456) begin
            mix_sat = 29'sh10000000;
        end else begin
            mix_sat = mix_rnd[MIX_W-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        band_next    = band_reg;
        tap_next     = tap_reg;
        chunk_next   = chunk_reg;
        head_next    = head_reg;
        v_next       = v_reg;
        mix_next     = mix_reg;
        m_valid_next = m_valid_reg;
        mac_ctrl     = '0;
        opnd_a       = '0;
        opnd_b       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    v_next = ($signed({s_sample_in[SAMPLE_W-1], s_sample_in})
                             - ($signed({ih_reg[1][SAMPLE_W-1], ih_reg[1]}) <<< 1)
                             + $signed({ih_reg[3][SAMPLE_W-1], ih_reg[3]})) <<< 5;
                    band_next        = '0;
                    tap_next         = '0;
                    chunk_next       = 1'b0;
                    mix_next         = '0;
                    mac_ctrl.acc_clr = 1'b1;
                    state_next       = ST_MUL;
                end
            end
            ST_MUL: begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_hi = chunk_reg;
                opnd_a = (tap_reg == 3'd0) ? v_reg : hist_opnd;
                opnd_b = chunk_reg ? $signed({coef_cur[63], coef_cur[63:32]})
                                   : $signed({1'b0, coef_cur[31:0]});
                state_next = ST_ACC;
            end
            ST_ACC: begin
                mac_ctrl.acc_en = 1'b1;
                chunk_next      = ~chunk_reg;
                if (!chunk_reg) begin
                    state_next = ST_MUL;
                end else if (tap_reg == TAP_LAST) begin
                    state_next = ST_FIN;
                end else begin
                    tap_next   = tap_reg + 3'd1;
                    state_next = ST_MUL;
                end
            end
            ST_FIN: begin
                state_next = ST_GMUL;
            end
            ST_GMUL: begin
                mac_ctrl.mul_en = 1'b1;
                opnd_a = $signed({17'd0, gain_reg[4'(band_reg)]});
                opnd_b = OPND_W'(bout_reg[band_reg]);
                state_next = ST_GACC;
            end
            ST_GACC: begin
                mix_next = mix_reg + prod[MIXACC_W-1:0];
                if (band_reg == BAND_W'(BAND_COUNT - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    band_next        = band_reg + BAND_W'(1);
                    tap_next         = '0;
                    mac_ctrl.acc_clr = 1'b1;
                    state_next       = ST_MUL;
                end
            end
            ST_DONE: begin
                head_next    = head_reg - 2'd1;
                m_valid_next = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            band_reg    <= '0;
            tap_reg     <= '0;
            chunk_reg   <= 1'b0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                ih_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            band_reg    <= band_next;
            tap_reg     <= tap_next;
            chunk_reg   <= chunk_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_DONE) begin
                ih_reg[3] <= ih_reg[2];
                ih_reg[2] <= ih_reg[1];
                ih_reg[1] <= ih_reg[0];
                ih_reg[0] <= smp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        v_reg   <= v_next;
        mix_reg <= mix_next;
        if (state_reg == ST_IDLE && s_valid) begin
            smp_reg <= s_sample_in;
            for (int i = 0; i < MAX_BANDS; i++) begin
                gain_reg[i] <= gain_arr[i];
            end
        end
        if (state_reg == ST_FIN) begin
            bout_reg[band_reg] <= bo_sat;
        end
        if (state_reg == ST_DONE) begin
            mix_out_reg <= mix_sat;
        end
    end

    // band history: per-band ring of four, shared head pointer
    assign rslot = head_next + tap_next[1:0] - 2'd1;
    assign raddr = HADDR_W'({band_next, rslot});
    assign waddr = HADDR_W'({band_reg, 2'(head_reg + 2'd3)});

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN) begin
            hist_mem[waddr] <= y_sat;
        end
        hrd_reg <= hist_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg <= '0;
            hrd_vld_reg  <= 1'b0;
        end else begin
            if (state_reg == ST_FIN) begin
                hist_vld_reg[waddr] <= 1'b1;
            end
            hrd_vld_reg <= hist_vld_reg[raddr];
        end
    end

    geq_mac u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .prod   (prod),
        .acc    (acc)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_mix_out   = mix_out_reg;
    assign m_band0_out = band_port[0];
    assign m_band1_out = band_port[1];
    assign m_band2_out = band_port[2];
    assign m_band3_out = band_port[3];
    assign m_band4_out = band_port[4];
    assign m_band5_out = band_port[5];
    assign m_band6_out = band_port[6];
    assign m_band7_out = band_port[7];
    assign m_band8_out = band_port[8];
    assign m_band9_out = band_port[9];

    `GEQ_ASSERT_IMP(a_ready_no_result, aclk, aresetn, s_ready, !m_valid_reg, "ready with result pending")
    `GEQ_ASSERT_NXT(a_start, aclk, aresetn, s_valid && s_ready, (state_reg == ST_MUL) && (tap_reg == 3'd0) && (band_reg == '0), "bad start of item")
    `GEQ_ASSERT_NXT(a_last_band, aclk, aresetn, (state_reg == ST_GACC) && (band_reg == BAND_W'(BAND_COUNT - 1)), state_reg == ST_DONE, "missed end of item")
    `GEQ_ASSERT_NXT(a_head_hold, aclk, aresetn, state_reg != ST_DONE, $stable(head_reg), "history head moved mid item")

endmodule

`default_nettype wire

// ===== test/ten_band_iir_graphic_equalizer_tb.sv =====
// ---------------------------------------------------------------------------
// Ten-band graphic equalizer testbench
// Drives samples and band gains over the s_ channel, predicts every band
// output and the gain-weighted mix with a bit-exact fixed-point model of the
// ten bandpass filters, and checks each m_ transfer against it in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ten_band_iir_graphic_equalizer_tb;
    import geq_pkg::*;

    localparam int RATE_HZ      = 48000;
    localparam int BANDS        = 10;
    localparam int LOW_HZ       = 32;
    localparam int CBITS        = 48;
    localparam int RANDOM_ITEMS = 1830;
    localparam longint CYCLE_LIMIT = 5_000_000;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [GAIN_W-1:0]          gain [MAX_BANDS];
    } eq_input_t;

    typedef struct {
        logic signed [MIX_W-1:0]    mix;
        logic signed [SAMPLE_W-1:0] band [MAX_BANDS];
    } eq_result_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in;
    logic [GAIN_W-1:0] s_gain [MAX_BANDS];
    logic m_valid;
    logic m_ready;
    logic signed [MIX_W-1:0] m_mix_out;
    logic signed [SAMPLE_W-1:0] m_band [MAX_BANDS];

    ten_band_iir_graphic_equalizer #(
        .SAMPLE_RATE(RATE_HZ),
        .BAND_COUNT(BANDS),
        .LOWEST_CENTER_HZ(LOW_HZ),
        .COEF_BITS(CBITS)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample_in(s_sample_in),
        .s_gain_band0(s_gain[0]), .s_gain_band1(s_gain[1]), .s_gain_band2(s_gain[2]),
        .s_gain_band3(s_gain[3]), .s_gain_band4(s_gain[4]), .s_gain_band5(s_gain[5]),
        .s_gain_band6(s_gain[6]), .s_gain_band7(s_gain[7]), .s_gain_band8(s_gain[8]),
        .s_gain_band9(s_gain[9]),
        .m_valid(m_valid), .m_ready(m_ready), .m_mix_out(m_mix_out),
        .m_band0_out(m_band[0]), .m_band1_out(m_band[1]), .m_band2_out(m_band[2]),
        .m_band3_out(m_band[3]), .m_band4_out(m_band[4]), .m_band5_out(m_band[5]),
        .m_band6_out(m_band[6]), .m_band7_out(m_band[7]), .m_band8_out(m_band[8]),
        .m_band9_out(m_band[9])
    );

    eq_input_t  pending_samples [$];
    eq_result_t expected_outputs [$];
    eq_input_t  driven_item;
    longint     filter_coef [MAX_BANDS][NUM_TAPS];
    int         sample_hist [4];
    int         band_hist [MAX_BANDS][4];
    int         accepted_cnt;
    int         total_items = 0;
    int         mismatch_cnt;
    int         hold_cnt;
    bit         pressure_done;
    bit         stimulus_ready = 1'b0;
    longint     cycle_cnt;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // rounded Q36 product
    function automatic logic [127:0] q36_mul(input logic [127:0] a, input logic [127:0] b);
        return (a * b + (128'd1 << 35)) >> 36;
    endfunction

    function automatic longint bandpass_coef(input int k, input int j);
        logic [127:0] den, t, t2, t3, t4, r1, r3, mag, quo, rem;
        longint a, v, res, lim;
        den = 128'(RATE_HZ) * 128'd256;
        t   = ({64'd0, TWO_PI_Q44} * 128'(longint'(LOW_HZ) << k) + (den >> 1)) / den;
        t2  = q36_mul(t, t);
        t4  = q36_mul(t2, t2);
        t3  = q36_mul(t2, t);
        r3  = q36_mul({64'd0, SQRT2_Q36}, t3);
        r1  = q36_mul({64'd0, SQRT2_Q36}, t);
        a   = longint'(t4) + longint'(r3) + 9 * longint'(t2) + 4 * longint'(r1)
              + (64'sd16 <<< 36);
        case (j)
            0: v = longint'(t2);
            1: v = 4 * longint'(t4) + 2 * longint'(r3) - 8 * longint'(r1) - (64'sd64 <<< 36);
            2: v = 6 * longint'(t4) - 18 * longint'(t2) + (64'sd96 <<< 36);
            3: v = 4 * longint'(t4) - 2 * longint'(r3) + 8 * longint'(r1) - (64'sd64 <<< 36);
            default: v = longint'(t4) - longint'(r3) + 9 * longint'(t2) - 4 * longint'(r1)
                         + (64'sd16 <<< 36);
        endcase
        mag = 128'(v < 0 ? -v : v) << 44;
        quo = mag / 128'(a);
        rem = mag % 128'(a);
        if ((rem << 1) >= 128'(a)) quo = quo + 1;
        res = v < 0 ? -longint'(quo) : longint'(quo);
        lim = (64'sd1 <<< (CBITS - 1)) - 1;
        if (res > lim) res = lim;
        if (res < -lim - 1) res = -lim - 1;
        return res;
    endfunction

    function automatic wide_t clamp_wide(input wide_t v, input wide_t lo, input wide_t hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic equalize_sample(input eq_input_t it);
        eq_result_t r;
        wide_t xin, acc, y, bo, mix, g;
        xin = (wide_t'(it.sample) - 2 * wide_t'(sample_hist[1]) + wide_t'(sample_hist[3])) * 32;
        mix = 0;
        for (int k = 0; k < MAX_BANDS; k++) begin
            r.band[k] = '0;
            if (k < BANDS) begin
                acc = wide_t'(filter_coef[k][0]) * xin;
                for (int j = 0; j < 4; j++)
                    acc = acc - wide_t'(filter_coef[k][j+1]) * wide_t'(band_hist[k][j]);
                y = clamp_wide((acc + (wide_t'(1) <<< 43)) >>> 44,
                               -(wide_t'(1) <<< 31), (wide_t'(1) <<< 31) - 1);
                band_hist[k][3] = band_hist[k][2];
                band_hist[k][2] = band_hist[k][1];
                band_hist[k][1] = band_hist[k][0];
                band_hist[k][0] = int'(y);
                bo = clamp_wide((y + 16) >>> 5, -(wide_t'(1) <<< 23), (wide_t'(1) <<< 23) - 1);
                g = wide_t'({112'd0, it.gain[k]});
                mix = mix + g * bo;
                r.band[k] = bo[SAMPLE_W-1:0];
            end
        end
        mix = clamp_wide((mix + 8192) >>> 14, -(wide_t'(1) <<< 28), (wide_t'(1) <<< 28) - 1);
        r.mix = mix[MIX_W-1:0];
        sample_hist[3] = sample_hist[2];
        sample_hist[2] = sample_hist[1];
        sample_hist[1] = sample_hist[0];
        sample_hist[0] = int'(it.sample);
        expected_outputs.push_back(r);
    endtask

    task automatic add_item(input int sample, input int gain_val);
        eq_input_t it;
        it.sample = sample[SAMPLE_W-1:0];
        for (int k = 0; k < MAX_BANDS; k++)
            it.gain[k] = gain_val < 0 ? GAIN_W'($urandom_range(0, 32768)) : GAIN_W'(gain_val);
        pending_samples.push_back(it);
    endtask

    function automatic int draw_gain();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 0;
        if (sel == 1) return 32768;
        if (sel == 2) return $urandom_range(0, 65535);
        return $urandom_range(0, 32768);
    endfunction

    // stimulus
    initial begin
        eq_input_t it;
        int period, amp, len, mode;
        for (int k = 0; k < BANDS; k++)
            for (int j = 0; j < NUM_TAPS; j++)
                filter_coef[k][j] = bandpass_coef(k, j);
        sample_hist = '{default: 0};
        band_hist = '{default: '{default: 0}};

        add_item(0, 16384);
        add_item(8388607, 16384);
        add_item(0, 32768);
        add_item(-8388608, 32768);
        add_item(0, 0);
        add_item(8388607, 65535);
        add_item(-8388608, 65535);
        for (int i = 0; i < 8; i++)
            add_item(i[0] ? -8388608 : 8388607, 65535);
        for (int i = 0; i < 4; i++)
            add_item(i[1] ? -8388608 : 8388607, 32768);
        add_item(1, 1);
        add_item(-1, -1);

        while (pending_samples.size() < RANDOM_ITEMS + 21) begin
            mode = $urandom_range(0, 9);
            len = $urandom_range(4, 60);
            period = 2 << $urandom_range(0, 9);
            amp = $urandom_range(0, 8388607);
            for (int i = 0; i < len; i++) begin
                it.sample = (mode < 4)
                            ? SAMPLE_W'((i % period) < period / 2 ? amp : -amp - 1)
                            : SAMPLE_W'($urandom);
                if (mode == 9) it.sample = SAMPLE_W'(int'($urandom_range(0, 255)) - 128);
                for (int k = 0; k < MAX_BANDS; k++)
                    it.gain[k] = GAIN_W'(draw_gain());
                pending_samples.push_back(it);
            end
        end
        total_items = pending_samples.size();
        stimulus_ready = 1'b1;
    end

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int phase_of();
        return total_items == 0 ? 0 : (accepted_cnt * 4) / total_items;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                equalize_sample(driven_item);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_valid || s_ready) begin
                if (stimulus_ready && pending_samples.size() > 0
                    && !((phase_of() == 1 && roll(59)) || (phase_of() == 3 && roll(14)))) begin
                    driven_item = pending_samples.pop_front();
                    s_valid <= 1'b1;
                    s_sample_in <= driven_item.sample;
                    for (int k = 0; k < MAX_BANDS; k++) s_gain[k] <= driven_item.gain[k];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else if (!pressure_done && accepted_cnt >= 300) begin
            pressure_done <= 1'b1;
            hold_cnt <= 3000;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !((phase_of() == 2 && roll(59)) || (phase_of() == 3 && roll(14)));
        end
    end

    // monitor
    always @(posedge aclk) begin
        eq_result_t e;
        bit bad;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected transfer: mix %0d", m_mix_out);
            end else begin
                e = expected_outputs.pop_front();
                bad = (m_mix_out !== e.mix);
                for (int k = 0; k < MAX_BANDS; k++)
                    if (m_band[k] !== e.band[k]) bad = 1'b1;
                if (bad) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("mismatch: mix exp %0d got %0d", e.mix, m_mix_out);
                        for (int k = 0; k < MAX_BANDS; k++)
                            if (m_band[k] !== e.band[k])
                                $display("  band%0d exp %0d got %0d", k, e.band[k], m_band[k]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("ten_band_iir_graphic_equalizer_tb: done, errors");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_sample_in = '0;
        s_gain = '{default: '0};
        accepted_cnt = 0;
        mismatch_cnt = 0;
        hold_cnt = 0;
        pressure_done = 1'b0;
        cycle_cnt = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stimulus_ready);
        wait (accepted_cnt == total_items && expected_outputs.size() == 0);
        repeat (300) @(posedge aclk);
        if (mismatch_cnt == 0 && expected_outputs.size() == 0)
            $display("ten_band_iir_graphic_equalizer_tb: done, clean");
        else
            $display("ten_band_iir_graphic_equalizer_tb: done, errors");
        $finish;
    end

endmodule
